FILE: src/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

	localparam int unsigned DEPTH_DEF  = 1024;
	localparam int unsigned DATA_W_DEF = 32;
	localparam int unsigned FIELD_W    = 32;
	localparam int unsigned KIND_W     = 3;
	localparam int unsigned STATUS_W   = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_BACK  = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_BACK   = 3'd3,
		KIND_PEEK_FRONT = 3'd4,
		KIND_PEEK_BACK  = 3'd5
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

FILE: src/deq_if.sv
// Valid/ready channel interfaces for deque commands and responses.
interface deq_cmd_if;
	import deq_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [KIND_W-1:0]          kind;
	logic signed [FIELD_W-1:0]  value;

	modport source (output valid, kind, value, input ready);
	modport sink   (input valid, kind, value, output ready);
endinterface

interface deq_rsp_if #(
	parameter int unsigned CNT_W = 11
);
	import deq_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [FIELD_W-1:0]  data;
	logic [STATUS_W-1:0]        status;
	logic [CNT_W-1:0]           occupancy;
	logic                       is_empty;

	modport source (output valid, data, status, occupancy, is_empty, input ready);
	modport sink   (input valid, data, status, occupancy, is_empty, output ready);
endinterface

FILE: src/double_ended_queue.sv
// Top level of the bounded double-ended queue with a ring store.
//
// The queue holds up to DEPTH words in one synchronous RAM addressed by a
// head pointer (front element) and a tail pointer (slot past the back
// element); an element count tells full from empty. Each command beat
// carries one operation (push, pop or peek at either end) and returns
// exactly one response beat with the word, a status, the count after the
// operation and an empty flag. Every operation makes at most one RAM
// access, a write for a push or a read for a pop or peek, so a command is
// taken every cycle while the response side keeps up: throughput is one
// beat per clock. The edge that accepts a command also starts its RAM
// read and loads stage 1; stage 1 moves into the output register, which
// presents the response, whenever that register is free. While the
// sink holds off, stage 1 and the output register keep one beat each, so
// the command port drops ready once two responses are waiting. Pointers
// and count update at acceptance, so back-to-back commands see each
// other's effects without forwarding. A push to a full queue is dropped
// with status FULL; a pop or peek on an empty queue returns zero with
// status EMPTY. For a DATA_WIDTH under 32, stored words keep their low
// DATA_WIDTH bits and are sign-extended to 32 bits on the way out. No
// clearing pass is needed after reset: only occupied entries, each
// written by a push, are ever read.
module double_ended_queue #(
	parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = deq_pkg::DATA_W_DEF,
	localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic     clk,
	input  logic     arst_n,
	deq_cmd_if.sink  cmd,
	deq_rsp_if.source rsp
);
	import deq_pkg::*;

	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);

	// Architectural state.
	logic [ADDR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0]  cnt_q;

	// Stage 1: command accepted, RAM read in flight.
	logic              valid_s1;
	status_t           status_s1;
	logic [CNT_W-1:0]  occ_s1;
	logic              use_rd_s1;

	// Output register.
	logic              out_valid_q;
	logic [FIELD_W-1:0] data_q;
	status_t           status_q;
	logic [CNT_W-1:0]  occ_q;

	logic accept, adv_s1;
	logic full, empty;
	logic [ADDR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
	logic [ADDR_W-1:0] head_d, tail_d;
	logic [CNT_W-1:0]  cnt_d;
	status_t           status_d;
	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [DATA_WIDTH-1:0] wr_word, rd_word;
	logic [FIELD_W-1:0]    rd_field;

	// The output register frees up when empty or when the sink takes it;
	// stage 1 advances into it and the command port refills stage 1.
	assign adv_s1    = valid_s1 && (!out_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || adv_s1;
	assign accept    = cmd.valid && cmd.ready;

	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);

	// Ring pointer arithmetic wraps at DEPTH, which need not be a power of two.
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;

	// With DATA_WIDTH under 32, stored words keep the low DATA_WIDTH bits of
	// the pushed value; on a read they are sign-extended into the 32-bit field.
	generate
		if (DATA_WIDTH <= FIELD_W) begin : g_wr_narrow
			assign wr_word = cmd.value[DATA_WIDTH-1:0];
		end else begin : g_wr_wide
			assign wr_word = {{(DATA_WIDTH - FIELD_W){1'b0}}, cmd.value};
		end
		if (DATA_WIDTH >= FIELD_W) begin : g_rd_wide
			assign rd_field = rd_word[FIELD_W-1:0];
		end else begin : g_rd_narrow
			assign rd_field = {{(FIELD_W - DATA_WIDTH){rd_word[DATA_WIDTH-1]}}, rd_word};
		end
	endgenerate

	// Decode one operation: next pointers, next count, status and the single
	// RAM access it needs.
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		status_d = ST_OK;
		we       = 1'b0;
		re       = 1'b0;
		waddr    = head_dec;
		raddr    = head_q;
		case (kind_t'(cmd.kind))
			KIND_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					head_d = head_dec;
					waddr  = head_dec;
					we     = 1'b1;
					cnt_d  = cnt_q + 1'b1;
				end
			end
			KIND_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					tail_d = tail_inc;
					waddr  = tail_q;
					we     = 1'b1;
					cnt_d  = cnt_q + 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					raddr  = head_q;
					re     = 1'b1;
					head_d = head_inc;
					cnt_d  = cnt_q - 1'b1;
				end
			end
			KIND_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					raddr  = tail_dec;
					re     = 1'b1;
					tail_d = tail_dec;
					cnt_d  = cnt_q - 1'b1;
				end
			end
			KIND_PEEK_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					raddr = head_q;
					re    = 1'b1;
				end
			end
			KIND_PEEK_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					raddr = tail_dec;
					re    = 1'b1;
				end
			end
			default: begin
				// Unused kinds leave the state alone and report the count.
			end
		endcase
	end

	deq_ring_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (accept && we),
		.waddr (waddr),
		.wdata (wr_word),
		.re    (accept && re),
		.raddr (raddr),
		.rdata (rd_word)
	);

	// Pointers and count commit at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q  <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			occ_s1    <= cnt_d;
			use_rd_s1 <= re;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The RAM read data is held until stage 1 moves on, since no new read
	// issues while stage 1 is stalled.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_q   <= use_rd_s1 ? rd_field : '0;
			status_q <= status_s1;
			occ_q    <= occ_s1;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.data      = data_q;
	assign rsp.status    = status_q;
	assign rsp.occupancy = occ_q;
	assign rsp.is_empty  = (occ_q == '0);
endmodule

FILE: src/deq_ring_ram.sv
// Single-port-per-direction ring store with a registered read port.
module deq_ring_ram #(
	parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = deq_pkg::DATA_W_DEF,
	localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [ADDR_W-1:0]     waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [ADDR_W-1:0]     raddr,
	output logic [DATA_WIDTH-1:0] rdata
);
	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no new read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
